### rtl/host_mcu_mailbox_bridge_macros.svh
// Assertion macros shared by the mailbox bridge checkers.
`ifndef HOST_MCU_MAILBOX_BRIDGE_MACROS_SVH
`define HOST_MCU_MAILBOX_BRIDGE_MACROS_SVH

// Clocked assertion, switched off while reset is high
`define MMB_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset
`define MMB_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/mmb_pkg.sv
// Package of the mailbox bridge: action codes, strobe bits and transaction types.
`timescale 1ns / 1ps
`default_nettype none
package mmb_pkg;

   // Action codes carried in the request tuser
   localparam logic [3:0] ACT_HOST_WR   = 4'd0;
   localparam logic [3:0] ACT_HOST_RD   = 4'd1;
   localparam logic [3:0] ACT_HOST_STAT = 4'd2;
   localparam logic [3:0] ACT_PORTA_WR  = 4'd3;
   localparam logic [3:0] ACT_PORTA_RD  = 4'd4;
   localparam logic [3:0] ACT_PORTB_WR  = 4'd5;
   localparam logic [3:0] ACT_PORTB_RD  = 4'd6;
   localparam logic [3:0] ACT_PORTC_RD  = 4'd7;
   localparam logic [3:0] ACT_MEM_RET   = 4'd8;

   // Port B strobe bit positions (active low on the pins)
   localparam int STB_TAKE_CMD   = 1;
   localparam int STB_POST_REPLY = 2;
   localparam int STB_BUS_REQ    = 3;
   localparam int STB_MEM_WR     = 4;
   localparam int STB_MEM_RD     = 5;
   localparam int STB_ADDR_LO    = 6;
   localparam int STB_ADDR_HI    = 7;

   // Port B reads back the pull-ups
   localparam logic [7:0] PORTB_PULLUPS = 8'hff;

   // Accepted request transaction
   typedef struct packed {
      logic [3:0] action;
      logic [7:0] data;
   } mmb_req_type;

   // One result transaction
   typedef struct packed {
      logic [15:0] mem_read_addr;
      logic        mem_read_en;
      logic [7:0]  mem_write_data;
      logic [15:0] mem_write_addr;
      logic        mem_write_en;
      logic        bus_request;
      logic        mcu_irq;
      logic [7:0]  read_data;
   } mmb_rsp_type;

endpackage
`default_nettype wire

### rtl/mmb_in_stage.sv
// Input register stage of the mailbox bridge.
`timescale 1ns / 1ps
`default_nettype none
module mmb_in_stage
   import mmb_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire mmb_req_type req_item,
   input  wire logic        advance,
   output logic             item_valid,
   output mmb_req_type      item
);

   logic        valid_ff, valid_in;
   mmb_req_type item_ff, item_in;

   // Take a new transaction whenever the held one leaves or none is held
   assign req_tready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (req_tready) begin
         valid_in = req_tvalid;
         item_in  = req_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule
`default_nettype wire

### rtl/mmb_core.sv
// Mailbox state: latches, flags, port A registers and address latch, updated per transaction.
`timescale 1ns / 1ps
`default_nettype none
module mmb_core
   import mmb_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        advance,
   input  wire mmb_req_type item,
   output mmb_rsp_type      result
);

   logic [7:0]  cmd_latch_ff, cmd_latch_in;
   logic [7:0]  reply_latch_ff, reply_latch_in;
   logic        cmd_ready_ff, cmd_ready_in;
   logic        reply_acc_ff, reply_acc_in;
   logic        bus_req_ff, bus_req_in;
   logic        irq_ff, irq_in;
   logic [7:0]  port_in_ff, port_in_in;
   logic [7:0]  port_out_ff, port_out_in;
   logic [15:0] addr_ff, addr_in;
   logic [7:0]  strobe;

   assign strobe = ~item.data;

   // Next state and result for the held transaction
   always_comb begin
      cmd_latch_in   = cmd_latch_ff;
      reply_latch_in = reply_latch_ff;
      cmd_ready_in   = cmd_ready_ff;
      reply_acc_in   = reply_acc_ff;
      bus_req_in     = bus_req_ff;
      irq_in         = irq_ff;
      port_in_in     = port_in_ff;
      port_out_in    = port_out_ff;
      addr_in        = addr_ff;
      result         = '0;
      case (item.action)
         ACT_HOST_WR: begin
            cmd_latch_in = item.data;
            cmd_ready_in = 1'b1;
            irq_in       = 1'b1;
         end
         ACT_HOST_RD: begin
            result.read_data = reply_latch_ff;
            reply_acc_in     = 1'b1;
         end
         ACT_HOST_STAT: begin
            result.read_data = ~{6'd0, reply_acc_ff, cmd_ready_ff};
         end
         ACT_PORTA_WR: begin
            port_out_in = item.data;
         end
         ACT_PORTA_RD: begin
            result.read_data = port_in_ff;
         end
         ACT_PORTB_WR: begin
            if (strobe[STB_TAKE_CMD]) begin
               irq_in       = 1'b0;
               cmd_ready_in = 1'b0;
               port_in_in   = cmd_latch_ff;
            end
            bus_req_in = strobe[STB_BUS_REQ];
            if (strobe[STB_POST_REPLY]) begin
               reply_latch_in = port_out_ff;
               reply_acc_in   = 1'b0;
            end
            // write then bump the low address byte, which wraps
            if (strobe[STB_MEM_WR]) begin
               result.mem_write_en   = 1'b1;
               result.mem_write_addr = addr_ff;
               result.mem_write_data = port_out_ff;
               addr_in = {addr_ff[15:8], addr_ff[7:0] + 8'd1};
            end
            // read uses the address after the bump
            if (strobe[STB_MEM_RD]) begin
               result.mem_read_en   = 1'b1;
               result.mem_read_addr = addr_in;
            end
            if (strobe[STB_ADDR_LO]) begin
               addr_in = {addr_in[15:8], port_out_ff};
            end
            if (strobe[STB_ADDR_HI]) begin
               addr_in = {port_out_ff, addr_in[7:0]};
            end
         end
         ACT_PORTB_RD: begin
            result.read_data = PORTB_PULLUPS;
         end
         ACT_PORTC_RD: begin
            result.read_data = {5'd0, ~bus_req_ff, reply_acc_ff, cmd_ready_ff};
         end
         ACT_MEM_RET: begin
            port_in_in = item.data;
         end
         default: begin
         end
      endcase
      result.mcu_irq     = irq_in;
      result.bus_request = bus_req_in;
   end

   // State commits when the transaction moves to the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_latch_ff   <= 8'd0;
         reply_latch_ff <= 8'd0;
         cmd_ready_ff   <= 1'b0;
         reply_acc_ff   <= 1'b1;
         bus_req_ff     <= 1'b0;
         irq_ff         <= 1'b0;
         port_in_ff     <= 8'd0;
         port_out_ff    <= 8'd0;
         addr_ff        <= 16'd0;
      end else if (advance) begin
         cmd_latch_ff   <= cmd_latch_in;
         reply_latch_ff <= reply_latch_in;
         cmd_ready_ff   <= cmd_ready_in;
         reply_acc_ff   <= reply_acc_in;
         bus_req_ff     <= bus_req_in;
         irq_ff         <= irq_in;
         port_in_ff     <= port_in_in;
         port_out_ff    <= port_out_in;
         addr_ff        <= addr_in;
      end
   end

endmodule
`default_nettype wire

### rtl/mmb_out_stage.sv
// Result register of the mailbox bridge.
`timescale 1ns / 1ps
`default_nettype none
module mmb_out_stage
   import mmb_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        item_valid,
   input  wire mmb_rsp_type result,
   output logic             advance,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output mmb_rsp_type      rsp_item
);

   logic        valid_ff, valid_in;
   mmb_rsp_type data_ff, data_in;

   // Load when the register is empty or its transaction is being taken
   assign advance = item_valid && (!valid_ff || rsp_tready);

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (advance) begin
         valid_in = 1'b1;
         data_in  = result;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_item   = data_ff;

endmodule
`default_nettype wire

### rtl/host_mcu_mailbox_bridge.sv
// Top level of the host to microcontroller mailbox bridge.
// Each request transaction is one register access from the host or the microcontroller
// (action code in req_tuser, byte in req_tdata) and gives exactly one response
// transaction after the input register and then the result register, carrying the read
// byte, the interrupt and bus request lines and any host memory write or read request.
// One transaction is taken every cycle while the response side keeps up: the mailbox
// update is combinational logic between the input register and the result register,
// and a transaction only waits when the result register is still held by the consumer.
`timescale 1ns / 1ps
`default_nettype none
module host_mcu_mailbox_bridge
   import mmb_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,  // [7:0] data
   input  wire logic [3:0]  req_tuser,  // [3:0] action
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [7:0] read_data, [8] mcu_irq, [9] bus_request, [10] mem_write_en,
   // [26:11] mem_write_addr, [34:27] mem_write_data, [35] mem_read_en,
   // [51:36] mem_read_addr, [55:52] zero
   output logic [55:0]      rsp_tdata
);

   mmb_req_type req_item;
   mmb_req_type item;
   mmb_rsp_type result;
   mmb_rsp_type rsp_item;
   logic        item_valid;
   logic        advance;

   assign req_item.action = req_tuser;
   assign req_item.data   = req_tdata;

   mmb_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   mmb_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item),
      .result  (result)
   );

   mmb_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .result     (result),
      .advance    (advance),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_item   (rsp_item)
   );

   assign rsp_tdata = {4'd0, rsp_item};

endmodule
`default_nettype wire

### rtl/mmb_checker.sv
// Port checker for the mailbox bridge, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "host_mcu_mailbox_bridge_macros.svh"
module mmb_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [55:0] rsp_tdata
);

   // No response right after reset
   `MMB_ASSERT_ALWAYS(a_idle_after_reset, clock, $past(reset) |-> !rsp_tvalid, "response after reset")
   // A stalled response is held
   `MMB_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "stalled response changed")
   // Write address and data are zero without a write
   `MMB_ASSERT(a_wr_quiet, clock, reset, rsp_tvalid && !rsp_tdata[10] |-> rsp_tdata[34:11] == 24'd0, "write fields set without write")
   // Read address is zero without a read
   `MMB_ASSERT(a_rd_quiet, clock, reset, rsp_tvalid && !rsp_tdata[35] |-> rsp_tdata[51:36] == 16'd0, "read address set without read")
   // An accepted request with no pending response gives a response after the input and result registers
   `MMB_ASSERT(a_latency, clock, reset, req_tvalid && req_tready && !rsp_tvalid && rsp_tready |=> ##1 rsp_tvalid, "response missing")

endmodule

bind host_mcu_mailbox_bridge mmb_checker u_mmb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire
